/* rtl/elf_pkg.sv */
// ----------------------------------------------------------------------------
// elf_pkg
// shared types, codes and constants of the e-paper line data formatter
// ----------------------------------------------------------------------------
package elf_pkg;

   // panel geometry
   localparam int LINE_COUNT = 128;
   localparam int SCAN_BYTES = 16;

   // depth of the queue between front and back
   localparam int FIFO_DEPTH = 2;

   // command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_PIXEL = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // update stages
   localparam logic [1:0] STAGE_COMPENSATE = 2'd0;
   localparam logic [1:0] STAGE_WHITE      = 2'd1;
   localparam logic [1:0] STAGE_INVERSE    = 2'd2;
   localparam logic [1:0] STAGE_NORMAL     = 2'd3;

   // fixed patterns
   localparam logic [7:0]  ODD_SCAN_BASE  = 8'hc0;
   localparam logic [7:0]  EVEN_SCAN_BASE = 8'h03;
   localparam logic [15:0] MASK_NIBBLE    = 16'h0f0f;
   localparam logic [15:0] MASK_PAIR      = 16'h3333;
   localparam logic [15:0] MASK_EVEN      = 16'h5555;
   localparam logic [15:0] MASK_ODD       = 16'haaaa;
   localparam logic [7:0]  BORDER_NORMAL  = 8'haa;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] line_number;
      logic [1:0] stage;
      logic       use_fixed;
      logic [7:0] fixed_byte;
      logic [7:0] image_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // kind of run the back end plays out
   typedef enum logic [1:0] {
      KIND_ODD   = 2'd0,
      KIND_PIXEL = 2'd1,
      KIND_EVEN  = 2'd2
   } kind_type;

   // one classified job
   typedef struct packed {
      kind_type   kind;
      logic       hit;       // scan run has one nonzero byte
      logic [3:0] hit_idx;   // index of that byte
      logic [7:0] byte_a;    // scan byte, or pixel high byte
      logic [7:0] byte_b;    // border byte, or pixel low byte
   } job_type;

   // spread 8 pixel bits to the even positions of 16 bits
   function automatic logic [15:0] spread_bits(input logic [7:0] b);
      logic [15:0] p;
      p = {8'h00, b};
      p = (p | (p << 4)) & MASK_NIBBLE;
      p = (p | (p << 2)) & MASK_PAIR;
      p = (p | (p << 1)) & MASK_EVEN;
      return p;
   endfunction

   function automatic logic [15:0] map_stage(input logic [15:0] p, input logic [1:0] st);
      logic [15:0] w;
      unique case (st)
         STAGE_COMPENSATE: w = MASK_ODD | (p ^ MASK_EVEN);
         STAGE_WHITE:      w = MASK_EVEN + (p ^ MASK_EVEN);
         STAGE_INVERSE:    w = MASK_EVEN | ((p ^ MASK_EVEN) << 1);
         default:          w = MASK_ODD | p;
      endcase
      return w;
   endfunction

endpackage

/* rtl/elf_front.sv */
// ----------------------------------------------------------------------------
// elf_front
// accepts commands, holds start-line settings and classifies each word
// ----------------------------------------------------------------------------
module elf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  elf_pkg::req_type req_data,
   output logic             job_valid,
   input  logic             job_ready,
   output elf_pkg::job_type job_data
);

   logic [6:0] held_line_ff, held_line_in;
   logic [1:0] held_stage_ff, held_stage_in;
   logic       held_fixed_mode_ff, held_fixed_mode_in;
   logic [7:0] held_fixed_byte_ff, held_fixed_byte_in;

   logic        accept;
   logic        is_start;
   logic        in_range;
   logic [15:0] word;

   assign req_ready = job_ready;
   assign accept    = req_valid & req_ready;
   assign is_start  = (req_data.command == elf_pkg::CMD_START);

   // start sees its own fields, the rest see the held copy
   always_comb begin
      held_line_in       = held_line_ff;
      held_stage_in      = held_stage_ff;
      held_fixed_mode_in = held_fixed_mode_ff;
      held_fixed_byte_in = held_fixed_byte_ff;
      if (is_start) begin
         held_line_in       = req_data.line_number;
         held_stage_in      = req_data.stage;
         held_fixed_mode_in = req_data.use_fixed;
         held_fixed_byte_in = req_data.fixed_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_line_ff       <= '0;
         held_stage_ff      <= '0;
         held_fixed_mode_ff <= 1'b0;
         held_fixed_byte_ff <= '0;
      end else if (accept) begin
         held_line_ff       <= held_line_in;
         held_stage_ff      <= held_stage_in;
         held_fixed_mode_ff <= held_fixed_mode_in;
         held_fixed_byte_ff <= held_fixed_byte_in;
      end
   end

   assign in_range = (9'(held_line_in) < 9'(elf_pkg::LINE_COUNT));
   assign word     = elf_pkg::map_stage(elf_pkg::spread_bits(req_data.image_byte),
                                        held_stage_ff);

   always_comb begin
      job_data.hit_idx = held_line_in[6:3];
      job_valid        = req_valid;
      unique case (req_data.command)
         elf_pkg::CMD_START: begin
            job_data.kind   = elf_pkg::KIND_ODD;
            job_data.hit    = held_line_in[0] & in_range;
            job_data.byte_a = elf_pkg::ODD_SCAN_BASE >> {held_line_in[2:1], 1'b0};
            job_data.byte_b = '0;
         end
         elf_pkg::CMD_PIXEL: begin
            job_data.kind   = elf_pkg::KIND_PIXEL;
            job_data.hit    = 1'b0;
            job_data.byte_a = held_fixed_mode_ff ? held_fixed_byte_ff : word[15:8];
            job_data.byte_b = held_fixed_mode_ff ? held_fixed_byte_ff : word[7:0];
         end
         elf_pkg::CMD_END: begin
            job_data.kind   = elf_pkg::KIND_EVEN;
            job_data.hit    = ~held_line_in[0] & in_range;
            job_data.byte_a = elf_pkg::EVEN_SCAN_BASE << {held_line_in[2:1], 1'b0};
            job_data.byte_b = (held_stage_ff == elf_pkg::STAGE_NORMAL) ?
                              elf_pkg::BORDER_NORMAL : 8'h00;
         end
         default: begin
            // unknown command is taken and dropped
            job_data.kind   = elf_pkg::KIND_PIXEL;
            job_data.hit    = 1'b0;
            job_data.byte_a = '0;
            job_data.byte_b = '0;
            job_valid       = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/elf_fifo.sv */
// ----------------------------------------------------------------------------
// elf_fifo
// short job queue between front and back
// ----------------------------------------------------------------------------
module elf_fifo #(
   parameter int DEPTH = elf_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  elf_pkg::job_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output elf_pkg::job_type out_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   elf_pkg::job_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* rtl/elf_back.sv */
// ----------------------------------------------------------------------------
// elf_back
// plays out one job as a run of bytes into the output register
// ----------------------------------------------------------------------------
module elf_back #(
   parameter int SCAN_BYTES = elf_pkg::SCAN_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  elf_pkg::job_type job_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output elf_pkg::rsp_type rsp_data
);

   localparam int SW = $clog2(SCAN_BYTES + 1);

   logic             busy_ff, busy_in;
   elf_pkg::job_type job_ff;
   logic [SW-1:0]    cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   elf_pkg::rsp_type rsp_ff;

   logic          out_fire;
   logic          last_now;
   logic          load;
   logic [SW-1:0] scan_idx;
   logic [7:0]    byte_now;

   assign out_fire  = busy_ff & (~rsp_valid_ff | rsp_ready);
   assign load      = job_valid & (~busy_ff | (out_fire & last_now));
   assign job_ready = ~busy_ff | (out_fire & last_now);

   always_comb begin
      scan_idx = cnt_ff;
      last_now = 1'b0;
      byte_now = '0;
      unique case (job_ff.kind)
         elf_pkg::KIND_ODD: begin
            last_now = (cnt_ff == SW'(SCAN_BYTES - 1));
            if (job_ff.hit && (8'(scan_idx) == 8'(job_ff.hit_idx))) begin
               byte_now = job_ff.byte_a;
            end
         end
         elf_pkg::KIND_EVEN: begin
            // descending scan, then the border byte
            scan_idx = SW'(SCAN_BYTES - 1) - cnt_ff;
            last_now = (cnt_ff == SW'(SCAN_BYTES));
            if (last_now) begin
               byte_now = job_ff.byte_b;
            end else if (job_ff.hit && (8'(scan_idx) == 8'(job_ff.hit_idx))) begin
               byte_now = job_ff.byte_a;
            end
         end
         default: begin
            last_now = (cnt_ff == SW'(1));
            byte_now = last_now ? job_ff.byte_b : job_ff.byte_a;
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (out_fire) begin
         cnt_in = cnt_ff + 1'b1;
         if (last_now) begin
            busy_in = 1'b0;
         end
      end
      rsp_valid_in = out_fire | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job_data;
      end
      if (out_fire) begin
         rsp_ff.out_byte <= byte_now;
         rsp_ff.last     <= last_now;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= SW'(SCAN_BYTES)))
      else $error("step count past end of run");

   a_pixel_two: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && job_ff.kind == elf_pkg::KIND_PIXEL) |-> (cnt_ff <= SW'(1)))
      else $error("pixel run longer than two bytes");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (out_fire && last_now && !load) |=> !busy_ff)
      else $error("back end still busy after last byte");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !out_fire)
      else $error("output register overwritten while stalled");

endmodule

/* rtl/epaper_line_data_formatter.sv */
// ----------------------------------------------------------------------------
// epaper_line_data_formatter
// turns start, pixel and end commands into the panel line byte stream
// ----------------------------------------------------------------------------
// a run's first byte passes the queue entry, the back end's job register and the output register
// throughput: one output byte per cycle while rsp_ready is high; start gives
//   SCAN_BYTES bytes, pixel 2, end SCAN_BYTES + 1 at the output port
// the back end's single byte-per-cycle output register sets the rate
// reset: synchronous, active high; held line, stage and fixed fill clear to zero
// ----------------------------------------------------------------------------
module epaper_line_data_formatter #(
   parameter int SCAN_BYTES = elf_pkg::SCAN_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  elf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output elf_pkg::rsp_type rsp_data
);

   // classified jobs, front to queue
   logic             front_valid;
   logic             front_ready;
   elf_pkg::job_type front_job;

   // queue to back end
   logic             back_valid;
   logic             back_ready;
   elf_pkg::job_type back_job;

   // front: holds start settings, builds pixel words and scan hit info
   elf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job_data  (front_job)
   );

   // queue lets the front take words while the back end plays out a run
   elf_fifo #(
      .DEPTH (elf_pkg::FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_job),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_job)
   );

   // back end: one byte per cycle while the receiver is ready, into a registered output
   elf_back #(
      .SCAN_BYTES (SCAN_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job_data  (back_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/epaper_line_data_formatter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epaper_line_data_formatter_tb
// drives start, pixel and end commands into the line formatter and checks
// every byte of the line stream against a predictor kept in step with it
// ----------------------------------------------------------------------------
module epaper_line_data_formatter_tb;

   // command code that the block must swallow without output
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   // cycles with no word moving on either side before the run is called hung
   localparam int STALL_LIMIT = 2000;
   // length of the one long receiver hold-off
   localparam int LONG_HOLD = 300;
   // random start/pixel/end commands wanted after the directed part
   localparam int RANDOM_WORDS = 385;

   typedef struct packed {
      elf_pkg::req_type word;
      logic             drain_first;   // hold this word back until the stream is empty
   } stim_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   elf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   elf_pkg::rsp_type rsp_data;

   stim_type         pending_words[$];
   elf_pkg::rsp_type expected_bytes[$];

   // line settings latched by the latest start command
   logic [6:0] cur_line = '0;
   logic [1:0] cur_stage = elf_pkg::STAGE_COMPENSATE;
   logic       cur_fill_on = 1'b0;
   logic [7:0] cur_fill_byte = '0;

   int   error_count = 0;
   int   bytes_seen = 0;
   int   idle_cycles = 0;
   logic tail_phase = 1'b0;

   epaper_line_data_formatter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // line stream predictor
   // ------------------------------------------------------------------------
   function automatic void push_byte(input logic [7:0] value, input logic is_last);
      elf_pkg::rsp_type r;
      r.out_byte = value;
      r.last     = is_last;
      expected_bytes.push_back(r);
   endfunction

   function automatic void predict_line_bytes(input elf_pkg::req_type w);
      logic [15:0] spread;
      logic [15:0] pair_word;
      logic [7:0]  scan;
      int          idx;
      case (w.command)
         elf_pkg::CMD_START: begin
            cur_line      = w.line_number;
            cur_stage     = w.stage;
            cur_fill_on   = w.use_fixed;
            cur_fill_byte = w.fixed_byte;
            // odd-line scan, lowest index first; one byte marks an odd line
            for (idx = 0; idx < elf_pkg::SCAN_BYTES; idx++) begin
               scan = 8'h00;
               if (cur_line[0] && int'(cur_line) < elf_pkg::LINE_COUNT &&
                   int'(cur_line >> 3) == idx)
                  scan = elf_pkg::ODD_SCAN_BASE >> (cur_line & 7'd6);
               push_byte(scan, idx == elf_pkg::SCAN_BYTES - 1);
            end
         end
         elf_pkg::CMD_PIXEL: begin
            if (cur_fill_on) begin
               push_byte(cur_fill_byte, 1'b0);
               push_byte(cur_fill_byte, 1'b1);
            end else begin
               // pixel bits land on the even positions of a 16-bit pair word
               spread = '0;
               for (idx = 0; idx < 8; idx++)
                  spread[2 * idx] = w.image_byte[idx];
               case (cur_stage)
                  elf_pkg::STAGE_COMPENSATE:
                     pair_word = elf_pkg::MASK_ODD | (spread ^ elf_pkg::MASK_EVEN);
                  elf_pkg::STAGE_WHITE:
                     pair_word = elf_pkg::MASK_EVEN + (spread ^ elf_pkg::MASK_EVEN);
                  elf_pkg::STAGE_INVERSE:
                     pair_word = elf_pkg::MASK_EVEN | ((spread ^ elf_pkg::MASK_EVEN) << 1);
                  default:
                     pair_word = elf_pkg::MASK_ODD | spread;
               endcase
               push_byte(pair_word[15:8], 1'b0);
               push_byte(pair_word[7:0], 1'b1);
            end
         end
         elf_pkg::CMD_END: begin
            // even-line scan, highest index first, then the border byte
            for (idx = elf_pkg::SCAN_BYTES - 1; idx >= 0; idx--) begin
               scan = 8'h00;
               if (!cur_line[0] && int'(cur_line) < elf_pkg::LINE_COUNT &&
                   int'(cur_line >> 3) == idx)
                  scan = elf_pkg::EVEN_SCAN_BASE << (cur_line & 7'd6);
               push_byte(scan, 1'b0);
            end
            push_byte((cur_stage == elf_pkg::STAGE_NORMAL) ? elf_pkg::BORDER_NORMAL : 8'h00,
                      1'b1);
         end
         default: ;   // unknown command: no bytes, settings kept
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic elf_pkg::req_type make_word(input logic [1:0] cmd,
                                                  input logic [6:0] line,
                                                  input logic [1:0] st,
                                                  input logic fill_on,
                                                  input logic [7:0] fill,
                                                  input logic [7:0] img);
      elf_pkg::req_type w;
      w.command     = cmd;
      w.line_number = line;
      w.stage       = st;
      w.use_fixed   = fill_on;
      w.fixed_byte  = fill;
      w.image_byte  = img;
      return w;
   endfunction

   // command field set, every other field fully random
   function automatic elf_pkg::req_type random_word(input logic [1:0] cmd);
      elf_pkg::req_type w;
      w.command     = cmd;
      w.line_number = 7'($urandom);
      w.stage       = 2'($urandom);
      w.use_fixed   = 1'($urandom);
      w.fixed_byte  = 8'($urandom);
      w.image_byte  = 8'($urandom);
      return w;
   endfunction

   function automatic void queue_word(input elf_pkg::req_type w, input logic drain_first);
      stim_type s;
      s.word        = w;
      s.drain_first = drain_first;
      pending_words.push_back(s);
   endfunction

   // ------------------------------------------------------------------------
   // command driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : cmd_driver
      int       gap_left;
      stim_type head;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         // predict at the edge the word is taken
         if (req_valid && req_ready)
            predict_line_bytes(req_data);
         tail_phase <= (pending_words.size() < 60);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_words[0].drain_first && expected_bytes.size() != 0) begin
               // pause until every byte owed has come out
               req_valid <= 1'b0;
            end else begin
               head = pending_words.pop_front();
               req_valid <= 1'b1;
               req_data  <= head.word;
               // random idle burst after this word, none near the end
               if (pending_words.size() >= 60 && $urandom_range(0, 4) == 0)
                  gap_left = $urandom_range(1, 10);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // byte stream monitor and receiver stalls
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : byte_monitor
      int               hold_left;
      logic             long_hold_done;
      elf_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected byte %h last %b", $time,
                        rsp_data.out_byte, rsp_data.last);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %h actual %h", $time,
                           want.out_byte, rsp_data.out_byte);
                  error_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time,
                           want.last, rsp_data.last);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && bytes_seen >= 150) begin
            // long hold-off so the block backs up and stalls its input
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 9);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog on cycles with no word moving
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == STALL_LIMIT) begin
            $display("epaper_line_data_formatter test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int random_count;
      int n_pix;
      int k;
      int r;
      logic [1:0] cmd;

      // pixel and end before any start run on the reset settings
      queue_word(make_word(elf_pkg::CMD_PIXEL, 7'd0, 2'd0, 1'b0, 8'h00, 8'hff), 1'b0);
      queue_word(make_word(elf_pkg::CMD_END, 7'd0, 2'd0, 1'b0, 8'h00, 8'h00), 1'b0);
      // unknown command with every field set must leave the settings alone
      queue_word(make_word(CMD_UNKNOWN, 7'h7f, elf_pkg::STAGE_NORMAL, 1'b1, 8'hff, 8'hff),
                 1'b0);
      // top line, normal stage
      queue_word(make_word(elf_pkg::CMD_START, 7'd127, elf_pkg::STAGE_NORMAL, 1'b0, 8'hff,
                           8'h00), 1'b0);
      queue_word(make_word(elf_pkg::CMD_PIXEL, 7'd0, 2'd0, 1'b0, 8'h00, 8'h00), 1'b0);
      queue_word(make_word(elf_pkg::CMD_PIXEL, 7'd0, 2'd0, 1'b0, 8'h00, 8'ha5), 1'b0);
      queue_word(make_word(elf_pkg::CMD_END, 7'd0, 2'd0, 1'b0, 8'h00, 8'h00), 1'b0);
      // bottom line, compensate stage; sender waits for an empty stream first
      queue_word(make_word(elf_pkg::CMD_START, 7'd0, elf_pkg::STAGE_COMPENSATE, 1'b0, 8'h00,
                           8'hff), 1'b1);
      queue_word(make_word(elf_pkg::CMD_PIXEL, 7'd0, 2'd0, 1'b0, 8'h00, 8'hff), 1'b0);
      queue_word(make_word(elf_pkg::CMD_PIXEL, 7'd0, 2'd0, 1'b0, 8'h00, 8'h3c), 1'b0);
      queue_word(make_word(elf_pkg::CMD_END, 7'd0, 2'd0, 1'b0, 8'h00, 8'h00), 1'b0);
      // white stage on an odd line
      queue_word(make_word(elf_pkg::CMD_START, 7'd1, elf_pkg::STAGE_WHITE, 1'b0, 8'h5a,
                           8'h00), 1'b0);
      queue_word(make_word(elf_pkg::CMD_PIXEL, 7'd0, 2'd0, 1'b0, 8'h00, 8'h96), 1'b0);
      queue_word(make_word(elf_pkg::CMD_END, 7'd0, 2'd0, 1'b0, 8'h00, 8'h00), 1'b0);
      // inverse stage on a mid even line
      queue_word(make_word(elf_pkg::CMD_START, 7'd64, elf_pkg::STAGE_INVERSE, 1'b0, 8'h00,
                           8'h00), 1'b0);
      queue_word(make_word(elf_pkg::CMD_PIXEL, 7'd0, 2'd0, 1'b0, 8'h00, 8'hff), 1'b0);
      queue_word(make_word(elf_pkg::CMD_PIXEL, 7'd0, 2'd0, 1'b0, 8'h00, 8'h00), 1'b0);
      queue_word(make_word(elf_pkg::CMD_END, 7'd0, 2'd0, 1'b0, 8'h00, 8'h00), 1'b0);
      // fixed fill of all ones, image byte ignored
      queue_word(make_word(elf_pkg::CMD_START, 7'd85, elf_pkg::STAGE_INVERSE, 1'b1, 8'hff,
                           8'h00), 1'b0);
      queue_word(make_word(elf_pkg::CMD_PIXEL, 7'd0, 2'd0, 1'b0, 8'h00, 8'h12), 1'b0);
      queue_word(make_word(elf_pkg::CMD_END, 7'd0, 2'd0, 1'b0, 8'h00, 8'h00), 1'b0);
      // fixed fill of zeros in the normal stage
      queue_word(make_word(elf_pkg::CMD_START, 7'd6, elf_pkg::STAGE_NORMAL, 1'b1, 8'h00,
                           8'h00), 1'b0);
      queue_word(make_word(elf_pkg::CMD_PIXEL, 7'd0, 2'd0, 1'b0, 8'h00, 8'hff), 1'b0);
      queue_word(make_word(elf_pkg::CMD_END, 7'd0, 2'd0, 1'b0, 8'h00, 8'h00), 1'b0);

      // mostly whole lines with random content, some loose and unknown words
      random_count = 0;
      while (random_count < RANDOM_WORDS) begin
         r = $urandom_range(0, 9);
         if (r < 8) begin
            queue_word(random_word(elf_pkg::CMD_START), $urandom_range(0, 24) == 0);
            n_pix = $urandom_range(0, 6);
            for (k = 0; k < n_pix; k++)
               queue_word(random_word(elf_pkg::CMD_PIXEL), 1'b0);
            queue_word(random_word(elf_pkg::CMD_END), 1'b0);
            random_count += n_pix + 2;
         end else begin
            n_pix = $urandom_range(1, 3);
            for (k = 0; k < n_pix; k++) begin
               cmd = 2'($urandom_range(0, 3));
               queue_word(random_word(cmd), 1'b0);
               if (cmd != CMD_UNKNOWN)
                  random_count++;
            end
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // every word taken, then every byte out, then a short quiet tail
      while (pending_words.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("epaper_line_data_formatter test passed");
      else
         $display("epaper_line_data_formatter test failed");
      $finish;
   end

endmodule
